/* sv/ric_pkg.sv */
// Shared types and codes for the reference-counted inode cache table.
// No dependencies; every other file in the block imports this package.
package ric_pkg;

    typedef enum logic {
        CMD_GET = 1'b0,
        CMD_PUT = 1'b1
    } t_cmd;

    typedef enum logic [2:0] {
        ST_HIT         = 3'd0,
        ST_CLAIMED     = 3'd1,
        ST_FULL        = 3'd2,
        ST_RELEASED    = 3'd3,
        ST_DECREMENTED = 3'd4,
        ST_BAD_PUT     = 3'd5,
        ST_OVERFLOW    = 3'd6
    } t_status;

    // Request fields carried down the cell chain with the item.
    typedef struct packed {
        t_cmd        command;
        logic [15:0] inode_number;
        logic [6:0]  slot_index;
        logic        no_links;
    } t_req;

    // Progress flags of the item as it walks the chain.
    typedef struct packed {
        logic    valid;
        logic    done;
        logic    free_seen;
        logic    free_disk;
        t_status status;
    } t_flags;

endpackage

/* sv/refcounted_inode_cache_table.sv */
// Top level of the reference-counted inode cache table: a chain of slot cells,
// an end stage that forms the result, and the output register.
// Depends on ric_pkg and ric_cell.
//
//   channel   direction   handshake           payload
//   request   in          i_valid / o_ready   i_command, i_inode_number,
//                                             i_slot_index, i_no_links
//   result    out         o_valid / i_ready   o_status, o_slot_out,
//                                             o_count_out, o_free_on_disk
//
// An item's result reaches the output register after the item has walked the chain
// one cell per cycle, starting with cell 0 at the accepting edge, and has then
// passed the end stage. One item is in the chain at once, and reset clears every
// reference count. A result waits in the output register while i_ready is low; the
// next item is accepted as soon as the previous one has reached that register.
module refcounted_inode_cache_table #(
    parameter int unsigned SLOTS      = 128,
    parameter int unsigned COUNT_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_command,
    input  logic [15:0] i_inode_number,
    input  logic [6:0]  i_slot_index,
    input  logic        i_no_links,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic [6:0]  o_slot_out,
    output logic [7:0]  o_count_out,
    output logic        o_free_on_disk
);
    import ric_pkg::*;

    localparam int unsigned IW = $clog2(SLOTS);

    // Chain taps: position 0 is fed by the request port, position SLOTS is
    // the register of the last cell.
    t_req                  w_req      [SLOTS+1];
    t_flags                w_flags    [SLOTS+1];
    logic [IW-1:0]         w_hit_idx  [SLOTS+1];
    logic [COUNT_BITS-1:0] w_hit_cnt  [SLOTS+1];
    logic [IW-1:0]         w_free_idx [SLOTS+1];

    logic w_accept;
    logic w_finish;
    logic w_claim;
    logic r_busy;

    // End stage holds the item after the last cell until the output is free.
    t_req                  r_end_req;
    t_flags                r_end_flags;
    logic [IW-1:0]         r_end_hit_idx;
    logic [COUNT_BITS-1:0] r_end_hit_cnt;
    logic [IW-1:0]         r_end_free_idx;

    t_status     w_status;
    logic [IW-1:0] w_slot;
    logic [COUNT_BITS-1:0] w_cnt;
    logic        w_fd;
    logic [31:0] w_slot_ext;
    logic [31:0] w_cnt_ext;
    logic [6:0]  w_slot7;

    logic        r_out_valid;
    logic [2:0]  r_status;
    logic [6:0]  r_slot;
    logic [7:0]  r_count;
    logic        r_fd;

    assign o_ready  = !r_busy;
    assign w_accept = i_valid && !r_busy;

    assign w_req[0].command      = t_cmd'(i_command);
    assign w_req[0].inode_number = i_inode_number;
    assign w_req[0].slot_index   = i_slot_index;
    assign w_req[0].no_links     = i_no_links;
    assign w_flags[0]            = '{valid: w_accept, done: 1'b0, free_seen: 1'b0,
                                     free_disk: 1'b0, status: ST_HIT};
    assign w_hit_idx[0]          = '0;
    assign w_hit_cnt[0]          = '0;
    assign w_free_idx[0]         = '0;

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        ric_cell #(
            .SLOTS      (SLOTS),
            .COUNT_BITS (COUNT_BITS),
            .INDEX      (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_req       (w_req[g]),
            .i_flags     (w_flags[g]),
            .i_hit_idx   (w_hit_idx[g]),
            .i_hit_cnt   (w_hit_cnt[g]),
            .i_free_idx  (w_free_idx[g]),
            .i_claim     (w_claim),
            .i_claim_idx (r_end_free_idx),
            .i_claim_num (r_end_req.inode_number),
            .o_req       (w_req[g+1]),
            .o_flags     (w_flags[g+1]),
            .o_hit_idx   (w_hit_idx[g+1]),
            .o_hit_cnt   (w_hit_cnt[g+1]),
            .o_free_idx  (w_free_idx[g+1])
        );
    end

    assign w_finish = r_end_flags.valid && (!r_out_valid || i_ready);

    // Result selection. A slot that matched or was named by a put settles the
    // result in the chain; otherwise a get claims the lowest free slot it saw,
    // or reports a full table, and a put names a slot beyond the table.
    always_comb begin
        w_claim  = 1'b0;
        w_status = ST_FULL;
        w_slot   = '0;
        w_cnt    = '0;
        w_fd     = 1'b0;
        if (r_end_flags.done) begin
            w_status = r_end_flags.status;
            w_slot   = r_end_hit_idx;
            w_cnt    = r_end_hit_cnt;
            w_fd     = r_end_flags.free_disk;
        end else if (r_end_req.command == CMD_GET) begin
            if (r_end_flags.free_seen) begin
                w_claim  = w_finish;
                w_status = ST_CLAIMED;
                w_slot   = r_end_free_idx;
                w_cnt    = COUNT_BITS'(1);
            end
        end else begin
            w_status = ST_BAD_PUT;
        end
    end

    assign w_slot_ext = 32'(w_slot);
    assign w_cnt_ext  = 32'(w_cnt);
    // A put beyond the table reports the requested index as given.
    assign w_slot7    = (!r_end_flags.done && r_end_req.command == CMD_PUT) ?
                        r_end_req.slot_index : w_slot_ext[6:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy            <= 1'b0;
            r_end_flags.valid <= 1'b0;
            r_out_valid       <= 1'b0;
        end else begin
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_finish) begin
                r_busy <= 1'b0;
            end

            if (w_flags[SLOTS].valid) begin
                r_end_req      <= w_req[SLOTS];
                r_end_flags    <= w_flags[SLOTS];
                r_end_hit_idx  <= w_hit_idx[SLOTS];
                r_end_hit_cnt  <= w_hit_cnt[SLOTS];
                r_end_free_idx <= w_free_idx[SLOTS];
            end else if (w_finish) begin
                r_end_flags.valid <= 1'b0;
            end

            if (w_finish) begin
                r_out_valid <= 1'b1;
                r_status    <= w_status;
                r_slot      <= w_slot7;
                r_count     <= w_cnt_ext[7:0];
                r_fd        <= w_fd;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_status;
    assign o_slot_out     = r_slot;
    assign o_count_out    = r_count;
    assign o_free_on_disk = r_fd;

endmodule

/* sv/ric_cell.sv */
// One slot of the inode cache table: stored inode number, reference count,
// and the stage register that hands the item on to the next slot.
// Depends on ric_pkg.
module ric_cell #(
    parameter int unsigned SLOTS      = 128,
    parameter int unsigned COUNT_BITS = 8,
    parameter int unsigned INDEX      = 0,
    localparam int unsigned IW        = $clog2(SLOTS)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ric_pkg::t_req         i_req,
    input  ric_pkg::t_flags       i_flags,
    input  logic [IW-1:0]         i_hit_idx,
    input  logic [COUNT_BITS-1:0] i_hit_cnt,
    input  logic [IW-1:0]         i_free_idx,
    input  logic                  i_claim,
    input  logic [IW-1:0]         i_claim_idx,
    input  logic [15:0]           i_claim_num,
    output ric_pkg::t_req         o_req,
    output ric_pkg::t_flags       o_flags,
    output logic [IW-1:0]         o_hit_idx,
    output logic [COUNT_BITS-1:0] o_hit_cnt,
    output logic [IW-1:0]         o_free_idx
);
    import ric_pkg::*;

    localparam logic [IW-1:0]         MY_IDX  = IW'(INDEX);
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
    localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

    logic [15:0]           r_inode, n_inode;
    logic [COUNT_BITS-1:0] r_count, n_count;
    t_req                  r_req, n_req;
    t_flags                r_flags, n_flags;
    logic [IW-1:0]         r_hit_idx, n_hit_idx;
    logic [COUNT_BITS-1:0] r_hit_cnt, n_hit_cnt;
    logic [IW-1:0]         r_free_idx, n_free_idx;

    logic w_live;
    logic w_match;
    logic w_put_me;

    assign w_live   = (r_count != '0);
    assign w_match  = w_live && (r_inode == i_req.inode_number);
    assign w_put_me = (32'(i_req.slot_index) == 32'(INDEX));

    always_comb begin
        n_inode    = r_inode;
        n_count    = r_count;
        n_req      = i_req;
        n_flags    = i_flags;
        n_hit_idx  = i_hit_idx;
        n_hit_cnt  = i_hit_cnt;
        n_free_idx = i_free_idx;

        // A claim is written once the item has left the chain.
        if (i_claim && (i_claim_idx == MY_IDX)) begin
            n_inode = i_claim_num;
            n_count = CNT_ONE;
        end

        if (i_flags.valid) begin
            if (i_req.command == CMD_GET) begin
                if (!i_flags.done && w_match) begin
                    n_flags.done = 1'b1;
                    n_hit_idx    = MY_IDX;
                    if (r_count == CNT_MAX) begin
                        n_flags.status = ST_OVERFLOW;
                        n_hit_cnt      = r_count;
                    end else begin
                        n_count        = r_count + CNT_ONE;
                        n_flags.status = ST_HIT;
                        n_hit_cnt      = r_count + CNT_ONE;
                    end
                end else if (!w_live && !i_flags.free_seen) begin
                    n_flags.free_seen = 1'b1;
                    n_free_idx        = MY_IDX;
                end
            end else if (w_put_me) begin
                n_flags.done = 1'b1;
                n_hit_idx    = MY_IDX;
                if (!w_live) begin
                    n_flags.status = ST_BAD_PUT;
                    n_hit_cnt      = '0;
                end else if (r_count == CNT_ONE) begin
                    n_count           = '0;
                    n_flags.status    = ST_RELEASED;
                    n_flags.free_disk = i_req.no_links;
                    n_hit_cnt         = '0;
                end else begin
                    n_count        = r_count - CNT_ONE;
                    n_flags.status = ST_DECREMENTED;
                    n_hit_cnt      = r_count - CNT_ONE;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count       <= '0;
            r_flags.valid <= 1'b0;
        end else begin
            r_inode    <= n_inode;
            r_count    <= n_count;
            r_req      <= n_req;
            r_flags    <= n_flags;
            r_hit_idx  <= n_hit_idx;
            r_hit_cnt  <= n_hit_cnt;
            r_free_idx <= n_free_idx;
        end
    end

    assign o_req      = r_req;
    assign o_flags    = r_flags;
    assign o_hit_idx  = r_hit_idx;
    assign o_hit_cnt  = r_hit_cnt;
    assign o_free_idx = r_free_idx;

endmodule

/* sv/ric_checker.sv */
// Port-level checks for the reference-counted inode cache table, with the
// bind that attaches them to the top level. Depends on ric_pkg.
module ric_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [2:0]  o_status,
    input logic [6:0]  o_slot_out,
    input logic [7:0]  o_count_out,
    input logic        o_free_on_disk
);
    import ric_pkg::*;

    // A waiting result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_status) &&
            $stable(o_slot_out) && $stable(o_count_out) && $stable(o_free_on_disk)))
        else $error("result changed while stalled");

    // Only one item is in the chain: an accepted item blocks the next cycle.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("second item accepted while one is in flight");

    // Only a release can ask for a disk free.
    a_free_only_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_free_on_disk) |-> (o_status == ST_RELEASED))
        else $error("disk free on a result that is not a release");

    // A full table reports nothing else.
    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_FULL) |->
            (o_slot_out == 7'd0 && o_count_out == 8'd0 && !o_free_on_disk))
        else $error("table full result carries data");

    // A release or a bad put reports a zero count.
    a_count_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_RELEASED || o_status == ST_BAD_PUT)) |->
            (o_count_out == 8'd0))
        else $error("release or bad put reported with nonzero count");

endmodule

bind refcounted_inode_cache_table ric_checker u_ric_checker (.*);

/* tb/refcounted_inode_cache_table_tb.sv */
// Self-checking testbench for the reference-counted inode cache table.
// Depends on ric_pkg and the refcounted_inode_cache_table RTL; reads no files.
// A directed table, fill and overflow runs, then random traffic under four idling modes.
`timescale 1ns / 1ps

module refcounted_inode_cache_table_tb;
    import ric_pkg::*;

    localparam int         SLOTS      = 128;
    localparam int         POOL_SIZE  = 24;
    localparam logic [7:0] COUNT_MAX  = 8'd255;

    // One result item as the block reports it.
    typedef struct packed {
        t_status     status;
        logic [6:0]  slot;
        logic [7:0]  count;
        logic        free_disk;
    } t_result;

    // One row of the directed table. When has_want is set, the expected result is
    // written into the row by hand; otherwise the table model supplies it.
    typedef struct packed {
        t_cmd        cmd;
        logic [15:0] inode;
        logic [6:0]  slot;
        logic        no_links;
        logic        has_want;
        t_result     want;
    } t_row;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_valid        = 1'b0;
    logic        o_ready;
    logic        i_command      = 1'b0;
    logic [15:0] i_inode_number = 16'd0;
    logic [6:0]  i_slot_index   = 7'd0;
    logic        i_no_links     = 1'b0;
    logic        o_valid;
    logic        i_ready        = 1'b0;
    logic [2:0]  o_status;
    logic [6:0]  o_slot_out;
    logic [7:0]  o_count_out;
    logic        o_free_on_disk;

    // Shadow copy of the table: reference count and inode number per slot. The
    // inode number of a slot is only looked at while its count is nonzero.
    logic [7:0]  shadow_count[SLOTS];
    logic [15:0] shadow_inode[SLOTS];

    t_result     pending_results[$];
    t_row        directed_rows[$];
    t_result     last_outcome;
    int          mismatches     = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;

    refcounted_inode_cache_table dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_command      (i_command),
        .i_inode_number (i_inode_number),
        .i_slot_index   (i_slot_index),
        .i_no_links     (i_no_links),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_slot_out     (o_slot_out),
        .o_count_out    (o_count_out),
        .o_free_on_disk (o_free_on_disk)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Hard stop in case the block hangs. The slowest correct run, with every item
    // hit by the longest sender pause and receiver stall, is well under a third of this.
    initial begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic t_result outcome(t_status st, int slot, int count, logic free_disk);
        t_result r;
        r.status    = st;
        r.slot      = slot[6:0];
        r.count     = count[7:0];
        r.free_disk = free_disk;
        return r;
    endfunction

    // Applies one request to the shadow table and returns the result the block
    // must produce for it. A get first looks for an in-use slot with the same
    // inode number (lowest wins); only when none matches does it claim the lowest
    // free slot. A put on a free slot changes nothing.
    function automatic t_result apply_request(t_cmd cmd, logic [15:0] inode,
                                              logic [6:0] slot, logic no_links);
        int found;
        found = -1;
        if (cmd == CMD_GET) begin
            for (int i = 0; i < SLOTS; i++)
                if (found < 0 && shadow_count[i] != 8'd0 && shadow_inode[i] == inode)
                    found = i;
            if (found >= 0) begin
                // A count already at its ceiling is reported and left alone.
                if (shadow_count[found] == COUNT_MAX)
                    return outcome(ST_OVERFLOW, found, int'(shadow_count[found]), 1'b0);
                shadow_count[found] = shadow_count[found] + 8'd1;
                return outcome(ST_HIT, found, int'(shadow_count[found]), 1'b0);
            end
            for (int i = 0; i < SLOTS; i++)
                if (found < 0 && shadow_count[i] == 8'd0)
                    found = i;
            if (found < 0)
                return outcome(ST_FULL, 0, 0, 1'b0);
            shadow_inode[found] = inode;
            shadow_count[found] = 8'd1;
            return outcome(ST_CLAIMED, found, 1, 1'b0);
        end
        if (shadow_count[slot] == 8'd0)
            return outcome(ST_BAD_PUT, int'(slot), 0, 1'b0);
        // Dropping from one releases the slot; only then does no_links matter.
        if (shadow_count[slot] == 8'd1) begin
            shadow_count[slot] = 8'd0;
            return outcome(ST_RELEASED, int'(slot), 0, no_links);
        end
        shadow_count[slot] = shadow_count[slot] - 8'd1;
        return outcome(ST_DECREMENTED, int'(slot), int'(shadow_count[slot]), 1'b0);
    endfunction

    function automatic void add_row(t_cmd cmd, logic [15:0] inode, logic [6:0] slot,
                                    logic no_links, logic has_want, t_result want);
        t_row r;
        r.cmd      = cmd;
        r.inode    = inode;
        r.slot     = slot;
        r.no_links = no_links;
        r.has_want = has_want;
        r.want     = want;
        directed_rows.push_back(r);
    endfunction

    // Offers one request item and returns once it has been accepted. Called right
    // after a rising edge. When the sender is to idle, valid drops before the item is
    // offered; now and then a long pause lets the item arrive at any point of the
    // block's walk down its slot chain. The expectation is queued at the accepting
    // edge, so the shadow table always reflects exactly the accepted items.
    task automatic send_request(t_cmd cmd, logic [15:0] inode, logic [6:0] slot,
                                logic no_links, logic has_want, t_result want);
        t_result predicted;
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            if ($urandom_range(7) == 0)
                repeat ($urandom_range(150)) @(posedge i_clk);
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_valid        <= 1'b1;
        i_command      <= cmd;
        i_inode_number <= inode;
        i_slot_index   <= slot;
        i_no_links     <= no_links;
        do @(posedge i_clk); while (!o_ready);
        predicted    = apply_request(cmd, inode, slot, no_links);
        last_outcome = predicted;
        pending_results.push_back(has_want ? want : predicted);
    endtask

    // Holds the sender off until every result item has come back.
    task automatic wait_all_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    // The receiver drops ready at random; a stall percentage of zero keeps it high.
    always @(posedge i_clk)
        i_ready <= ($urandom_range(99) >= recv_stall_pct);

    task automatic compare_field(string name, logic [15:0] want_v, logic [15:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
            mismatches++;
        end
    endtask

    // Every result item is checked against the oldest outstanding expectation.
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual status %0d slot %0d",
                         $time, o_status, o_slot_out);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                compare_field("status", 16'(want.status), 16'(o_status));
                compare_field("slot_out", 16'(want.slot), 16'(o_slot_out));
                compare_field("count_out", 16'(want.count), 16'(o_count_out));
                compare_field("free_on_disk", 16'(want.free_disk), 16'(o_free_on_disk));
            end
        end
    end

    initial begin : stimulus
        logic [15:0] inode_pool[POOL_SIZE];
        logic [15:0] hot_inode;
        logic [6:0]  hot_slot;
        int          full_seen;
        int          roll;
        int          pick;
        int          send_mode[4];
        int          stall_mode[4];

        send_mode  = '{0, 87, 0, 33};
        stall_mode = '{0, 0, 87, 33};
        for (int i = 0; i < SLOTS; i++) begin
            shadow_count[i] = 8'd0;
            shadow_inode[i] = 16'd0;
        end

        // Directed part. Starting from an empty table: puts on free slots at both
        // ends of the index range, claims and hits at both extremes of the inode
        // number, a decrement that ignores no_links, releases with and without a
        // disk free, reuse of the lowest free slot, and a freed slot whose stale
        // inode number must not produce a hit.
        add_row(CMD_PUT, 16'h0000, 7'd0,   1'b0, 1'b1, outcome(ST_BAD_PUT, 0, 0, 1'b0));
        add_row(CMD_PUT, 16'h0000, 7'd127, 1'b1, 1'b1, outcome(ST_BAD_PUT, 127, 0, 1'b0));
        add_row(CMD_GET, 16'h0000, 7'd0,   1'b0, 1'b1, outcome(ST_CLAIMED, 0, 1, 1'b0));
        add_row(CMD_GET, 16'hFFFF, 7'd127, 1'b1, 1'b1, outcome(ST_CLAIMED, 1, 1, 1'b0));
        add_row(CMD_GET, 16'h0000, 7'd0,   1'b0, 1'b1, outcome(ST_HIT, 0, 2, 1'b0));
        add_row(CMD_GET, 16'hFFFF, 7'd0,   1'b0, 1'b1, outcome(ST_HIT, 1, 2, 1'b0));
        add_row(CMD_PUT, 16'h0000, 7'd0,   1'b1, 1'b1, outcome(ST_DECREMENTED, 0, 1, 1'b0));
        add_row(CMD_PUT, 16'h0000, 7'd0,   1'b1, 1'b1, outcome(ST_RELEASED, 0, 0, 1'b1));
        add_row(CMD_PUT, 16'h0000, 7'd0,   1'b0, 1'b1, outcome(ST_BAD_PUT, 0, 0, 1'b0));
        add_row(CMD_GET, 16'hA5A5, 7'd0,   1'b0, 1'b1, outcome(ST_CLAIMED, 0, 1, 1'b0));
        add_row(CMD_PUT, 16'h0000, 7'd1,   1'b0, 1'b1, outcome(ST_DECREMENTED, 1, 1, 1'b0));
        add_row(CMD_PUT, 16'h0000, 7'd1,   1'b0, 1'b1, outcome(ST_RELEASED, 1, 0, 1'b0));
        add_row(CMD_GET, 16'hFFFF, 7'd0,   1'b0, 1'b1, outcome(ST_CLAIMED, 1, 1, 1'b0));
        add_row(CMD_GET, 16'h5A5A, 7'd0,   1'b0, 1'b1, outcome(ST_CLAIMED, 2, 1, 1'b0));
        add_row(CMD_PUT, 16'hFFFF, 7'd127, 1'b0, 1'b1, outcome(ST_BAD_PUT, 127, 0, 1'b0));
        add_row(CMD_PUT, 16'h0000, 7'd2,   1'b1, 1'b1, outcome(ST_RELEASED, 2, 0, 1'b1));
        add_row(CMD_GET, 16'h0000, 7'd0,   1'b0, 1'b1, outcome(ST_CLAIMED, 2, 1, 1'b0));
        add_row(CMD_GET, 16'h0000, 7'd0,   1'b0, 1'b1, outcome(ST_HIT, 2, 2, 1'b0));
        add_row(CMD_GET, 16'h0001, 7'd0,   1'b0, 1'b0, '0);
        add_row(CMD_GET, 16'h8000, 7'd0,   1'b0, 1'b0, '0);
        add_row(CMD_PUT, 16'h0000, 7'd3,   1'b1, 1'b0, '0);
        add_row(CMD_PUT, 16'h0000, 7'd64,  1'b1, 1'b0, '0);
        add_row(CMD_GET, 16'hA5A5, 7'd0,   1'b0, 1'b0, '0);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r])
            send_request(directed_rows[r].cmd, directed_rows[r].inode, directed_rows[r].slot,
                         directed_rows[r].no_links, directed_rows[r].has_want,
                         directed_rows[r].want);
        wait_all_results();

        // Fill the table with fresh inode numbers until a get is refused a few
        // times, then show that a hit still succeeds on a full table.
        send_idle_pct  = 87;
        recv_stall_pct = 0;
        full_seen      = 0;
        while (full_seen < 3) begin
            send_request(CMD_GET, 16'($urandom_range(65535)), 7'($urandom_range(127)),
                         1'($urandom_range(1)), 1'b0, '0);
            if (last_outcome.status == ST_FULL)
                full_seen++;
        end
        hot_inode = shadow_inode[64];
        send_request(CMD_GET, hot_inode, 7'd0, 1'b0, 1'b0, '0);
        wait_all_results();

        // Drive the count of that slot to its ceiling, hit the ceiling twice, then
        // step back down by one and up again. The table stays full afterwards.
        send_idle_pct  = 33;
        recv_stall_pct = 33;
        do
            send_request(CMD_GET, hot_inode, 7'd0, 1'b0, 1'b0, '0);
        while (last_outcome.status != ST_OVERFLOW);
        hot_slot = last_outcome.slot;
        send_request(CMD_GET, hot_inode, 7'd0, 1'b1, 1'b0, '0);
        send_request(CMD_PUT, 16'h0000, hot_slot, 1'b1, 1'b0, '0);
        send_request(CMD_GET, hot_inode, 7'd0, 1'b0, 1'b0, '0);
        wait_all_results();

        // Random traffic. Most gets draw from a small pool of inode numbers so that
        // hits are common, and most puts target a slot that is in use; the rest are
        // gets of arbitrary numbers and puts on arbitrary slots.
        foreach (inode_pool[p])
            inode_pool[p] = 16'($urandom_range(65535));
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = send_mode[ph];
            recv_stall_pct = stall_mode[ph];
            for (int n = 0; n < 25; n++) begin
                roll = $urandom_range(99);
                if (roll < 45) begin
                    send_request(CMD_GET, inode_pool[$urandom_range(POOL_SIZE - 1)],
                                 7'($urandom_range(127)), 1'($urandom_range(1)), 1'b0, '0);
                end else if (roll < 85) begin
                    // Scan from a random slot for one that is in use.
                    pick = $urandom_range(SLOTS - 1);
                    for (int k = 0; k < SLOTS && shadow_count[pick] == 8'd0; k++)
                        pick = (pick + 1) % SLOTS;
                    send_request(CMD_PUT, 16'($urandom_range(65535)), 7'(pick),
                                 1'($urandom_range(1)), 1'b0, '0);
                end else if (roll < 93) begin
                    send_request(CMD_GET, 16'($urandom_range(65535)),
                                 7'($urandom_range(127)), 1'($urandom_range(1)), 1'b0, '0);
                end else begin
                    send_request(CMD_PUT, 16'($urandom_range(65535)),
                                 7'($urandom_range(127)), 1'($urandom_range(1)), 1'b0, '0);
                end
            end
            wait_all_results();
        end

        // Watch a little past one full chain walk for any stray result.
        repeat (SLOTS + 20) @(posedge i_clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* filelist.f */
sv/ric_pkg.sv
sv/ric_cell.sv
sv/refcounted_inode_cache_table.sv
sv/ric_checker.sv
tb/refcounted_inode_cache_table_tb.sv
